// File: rtl/core/qdp_pkg.sv
// ----------------------------------------------------------------------------
// qdp_pkg
// shared types for the quadrature decoder with period measurement
// ----------------------------------------------------------------------------
package qdp_pkg;

	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 88;

	typedef enum logic [1:0] {
		MOVE_NONE = 2'd0,
		MOVE_FWD  = 2'd1,
		MOVE_BACK = 2'd2,
		MOVE_BAD  = 2'd3
	} move_t;

	// one edge event
	typedef struct packed {
		logic        channel;
		logic        level;
		logic [31:0] time_us;
	} ev_t;

	// one result
	typedef struct packed {
		logic signed [31:0] position;
		logic        [15:0] error_total;
		logic        [31:0] period_us;
		move_t              move_kind;
		logic        [1:0]  step_now;
	} res_t;

endpackage

// File: rtl/core/qdp_in_reg.sv
// ----------------------------------------------------------------------------
// qdp_in_reg
// input register stage, holds one edge request until the core takes it
// ----------------------------------------------------------------------------
module qdp_in_reg import qdp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // level, time_us
	input  logic                  s_tuser,  // channel
	input  logic                  advance,
	output logic                  valid_s1,
	output ev_t                   ev_s1
);

	logic take;

	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_s1.channel <= s_tuser;
			ev_s1.level   <= s_tdata[0];
			ev_s1.time_us <= s_tdata[32:1];
		end
	end

endmodule

// File: rtl/core/qdp_core.sv
// ----------------------------------------------------------------------------
// qdp_core
// decoder state and single-pass update of position, errors and period
// ----------------------------------------------------------------------------
module qdp_core import qdp_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned TIME_WIDTH  = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  ev_t  ev_s1,
	output res_t res
);

	logic                   level_a_q;
	logic                   level_b_q;
	logic [1:0]             prev_step_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [15:0]            bad_q;
	logic [TIME_WIDTH-1:0]  start_q;
	logic [TIME_WIDTH-1:0]  period_q;

	logic                   a_d;
	logic                   b_d;
	logic                   changed;
	logic [1:0]             step;
	logic [1:0]             step_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic [15:0]            bad_d;
	logic [TIME_WIDTH-1:0]  now_t;
	logic [TIME_WIDTH-1:0]  start_d;
	logic [TIME_WIDTH-1:0]  period_d;
	move_t                  kind;

	assign now_t = TIME_WIDTH'(ev_s1.time_us);

	always_comb begin
		a_d      = ev_s1.channel ? level_a_q : ev_s1.level;
		b_d      = ev_s1.channel ? ev_s1.level : level_b_q;
		changed  = ev_s1.channel ? (ev_s1.level != level_b_q) : (ev_s1.level != level_a_q);
		step     = a_d ? (b_d ? 2'd3 : 2'd2) : (b_d ? 2'd0 : 2'd1);
		step_d   = prev_step_q;
		count_d  = count_q;
		bad_d    = bad_q;
		start_d  = start_q;
		period_d = period_q;
		kind     = MOVE_NONE;
		if (changed) begin
			step_d = step;
			if (step == prev_step_q + 2'd1) begin
				count_d = count_q + COUNT_WIDTH'(1);
				kind    = MOVE_FWD;
			end else if (step == prev_step_q - 2'd1) begin
				count_d = count_q - COUNT_WIDTH'(1);
				kind    = MOVE_BACK;
			end else begin
				if (bad_q != 16'hFFFF) begin
					bad_d = bad_q + 16'd1;
				end
				kind = MOVE_BAD;
			end
			// step 0 opens a cycle, step 3 closes it
			if (step == 2'd0) begin
				start_d = now_t;
			end else if (step == 2'd3) begin
				period_d = now_t - start_q;
			end
		end
	end

	assign res.position    = 32'(signed'(count_d));
	assign res.error_total = bad_d;
	assign res.period_us   = 32'(period_d);
	assign res.move_kind   = kind;
	assign res.step_now    = step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_a_q   <= 1'b0;
			level_b_q   <= 1'b0;
			prev_step_q <= 2'd0;
			count_q     <= '0;
			bad_q       <= '0;
			start_q     <= '0;
			period_q    <= '0;
		end else if (advance) begin
			level_a_q   <= a_d;
			level_b_q   <= b_d;
			prev_step_q <= step_d;
			count_q     <= count_d;
			bad_q       <= bad_d;
			start_q     <= start_d;
			period_q    <= period_d;
		end
	end

endmodule

// File: rtl/core/qdp_out_reg.sv
// ----------------------------------------------------------------------------
// qdp_out_reg
// result register, holds one result until the sink takes it
// ----------------------------------------------------------------------------
module qdp_out_reg import qdp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  res_t                   res,
	output logic                   room,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // position, error_total, period_us, step_now
	output logic [1:0]             m_tuser   // move_kind
);

	res_t res_s2;

	assign room = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (room) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {6'd0, res_s2.step_now, res_s2.period_us,
		res_s2.error_total, res_s2.position};
	assign m_tuser = res_s2.move_kind;

endmodule

// File: rtl/core/quadrature_decoder_with_period.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_with_period
// x4 quadrature decoder with step-cycle period measurement
// ----------------------------------------------------------------------------
// Takes one edge event per request and returns one result per request. An
// event is registered, the decoder state is updated combinationally and the
// result is registered: an event's result passes from the input register into
// the result register once that has room, and a new event is taken in every cycle
// while the result side takes results; the result register sets the throughput,
// and s_tready follows m_tready combinationally when both stages are full.
module quadrature_decoder_with_period import qdp_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned TIME_WIDTH  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // level, time_us
	input  logic                   s_tuser,  // channel
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // position, error_total, period_us, step_now
	output logic [1:0]             m_tuser   // move_kind
);

	logic valid_s1;
	logic room;
	logic advance;
	ev_t  ev_s1;
	res_t res;

	assign advance = valid_s1 && room;

	qdp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.ev_s1    (ev_s1)
	);

	qdp_core #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ev_s1   (ev_s1),
		.res     (res)
	);

	qdp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
